/* src/dsam_pkg.sv */
// shared types, codes and helpers of the dual-stream audio mixer
package dsam_pkg;

  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned STREAM_W = 4;
  localparam int unsigned FILL_W   = 15;

  // operation codes of an input item
  localparam logic [1:0] OP_PUSH  = 2'd0;
  localparam logic [1:0] OP_READ  = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 16'sh7fff;
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 16'sh8000;

  // what a full frame does, latched at its first sample
  typedef enum logic [1:0] {
    ACT_STORE   = 2'd0,
    ACT_MIX     = 2'd1,
    ACT_REPLACE = 2'd2
  } frame_act_t;

  // classification held in the front stage
  typedef enum logic [2:0] {
    S1_NONE,
    S1_PASS,
    S1_MIX,
    S1_REPL,
    S1_READ,
    S1_CLEAR
  } s1_kind_t;

  // command handed from front to back
  typedef enum logic [1:0] {
    CMD_PUSH,
    CMD_READ,
    CMD_CLEAR
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t                   kind;
    logic signed [SAMPLE_W-1:0]  value;
  } ring_cmd_t;

  // 16-bit add with saturation
  function automatic logic signed [SAMPLE_W-1:0] sat_add(
    input logic signed [SAMPLE_W-1:0] a,
    input logic signed [SAMPLE_W-1:0] b
  );
    logic signed [SAMPLE_W:0] s;
    begin
      s = {a[SAMPLE_W-1], a} + {b[SAMPLE_W-1], b};
      if (s[SAMPLE_W] != s[SAMPLE_W-1]) begin
        return s[SAMPLE_W] ? SAMPLE_MIN : SAMPLE_MAX;
      end
      return s[SAMPLE_W-1:0];
    end
  endfunction

endpackage

/* src/dsam_in_if.sv */
// input channel: operation, stream id, sample and frame flag
interface dsam_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         operation;
  logic [3:0]         stream_id;
  logic signed [15:0] sample_in;
  logic               frame_is_full;

  modport source (output valid, operation, stream_id, sample_in, frame_is_full,
                  input ready);
  modport sink (input valid, operation, stream_id, sample_in, frame_is_full,
                output ready);
endinterface

/* src/dsam_out_if.sv */
// result channel: read sample, empty flag and fill level
interface dsam_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] sample_out;
  logic               was_empty;
  logic [14:0]        fill_level;

  modport source (output valid, sample_out, was_empty, fill_level, input ready);
  modport sink (input valid, sample_out, was_empty, fill_level, output ready);
endinterface

/* src/dsam_ram.sv */
// generic single-write, single-read ram with registered read (read-first)
module dsam_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 80
) (
  input  logic                                 clk,
  input  logic                                 wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                     wr_data,
  input  logic                                 rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                     rd_data
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end
endmodule

/* src/dsam_front.sv */
// front part: accepts items, tracks frame state, reads pending frame, builds ring commands
module dsam_front #(
  parameter int unsigned FRAME_LEN = 80
) (
  input  logic                clk,
  input  logic                rst_n,
  dsam_in_if.sink             in_ch,
  output logic                q_valid,
  input  logic                q_ready,
  output dsam_pkg::ring_cmd_t q_cmd
);
  import dsam_pkg::*;

  localparam int unsigned PW = (FRAME_LEN > 1) ? $clog2(FRAME_LEN) : 1;
  localparam logic [PW-1:0] LAST_POS = PW'(FRAME_LEN - 1);

  logic                       pend_valid_r, pend_valid_nxt;
  logic [STREAM_W-1:0]        pend_stream_r, pend_stream_nxt;
  logic [PW-1:0]              pos_r, pos_nxt;
  frame_act_t                 act_r, act_nxt;
  logic                       s1_valid_r, s1_valid_nxt;
  s1_kind_t                   s1_kind_r, s1_kind_nxt;
  logic signed [SAMPLE_W-1:0] s1_sample_r, s1_sample_nxt;

  logic                       accept;
  logic                       is_frame;
  logic                       frame_end;
  logic                       s1_done;
  frame_act_t                 act_now;
  logic                       pf_wr_en;
  logic                       pf_rd_en;
  logic [SAMPLE_W-1:0]        pf_rd_data;
  logic signed [SAMPLE_W-1:0] pf_old;

  assign accept    = in_ch.valid && in_ch.ready;
  assign is_frame  = accept && (in_ch.operation == OP_PUSH) && in_ch.frame_is_full;
  assign frame_end = (pos_r == LAST_POS);
  assign s1_done   = s1_valid_r && ((s1_kind_r == S1_NONE) || q_ready);
  assign in_ch.ready = !s1_valid_r || s1_done;

  // action decided at a frame's first sample, held for the rest
  always_comb begin
    if (pos_r == '0) begin
      if (!pend_valid_r) begin
        act_now = ACT_STORE;
      end else if (in_ch.stream_id != pend_stream_r) begin
        act_now = ACT_MIX;
      end else begin
        act_now = ACT_REPLACE;
      end
    end else begin
      act_now = act_r;
    end
  end

  // mixed sums are never read back, so only store and replace write
  assign pf_wr_en = is_frame && (act_now != ACT_MIX);
  assign pf_rd_en = is_frame && (act_now != ACT_STORE);

  dsam_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (FRAME_LEN)
  ) u_pend_ram (
    .clk     (clk),
    .wr_en   (pf_wr_en),
    .wr_addr (pos_r),
    .wr_data (in_ch.sample_in),
    .rd_en   (pf_rd_en),
    .rd_addr (pos_r),
    .rd_data (pf_rd_data)
  );

  assign pf_old = pf_rd_data;

  // frame state
  always_comb begin
    pend_valid_nxt  = pend_valid_r;
    pend_stream_nxt = pend_stream_r;
    pos_nxt         = pos_r;
    act_nxt         = act_r;
    if (accept) begin
      unique case (in_ch.operation)
        OP_PUSH: begin
          if (in_ch.frame_is_full) begin
            act_nxt = act_now;
            pos_nxt = frame_end ? '0 : pos_r + PW'(1);
            if (frame_end) begin
              if (act_now == ACT_STORE) begin
                pend_valid_nxt  = 1'b1;
                pend_stream_nxt = in_ch.stream_id;
              end else if (act_now == ACT_MIX) begin
                pend_valid_nxt = 1'b0;
              end
            end
          end
        end
        OP_CLEAR: begin
          pend_valid_nxt = 1'b0;
          pos_nxt        = '0;
          act_nxt        = ACT_STORE;
        end
        default: begin
        end
      endcase
    end
  end

  // stage register classification
  always_comb begin
    s1_valid_nxt  = s1_valid_r;
    s1_kind_nxt   = s1_kind_r;
    s1_sample_nxt = s1_sample_r;
    if (accept) begin
      s1_valid_nxt  = 1'b1;
      s1_sample_nxt = in_ch.sample_in;
      unique case (in_ch.operation)
        OP_PUSH: begin
          if (!in_ch.frame_is_full) begin
            s1_kind_nxt = S1_PASS;
          end else if (act_now == ACT_MIX) begin
            s1_kind_nxt = S1_MIX;
          end else if (act_now == ACT_REPLACE) begin
            s1_kind_nxt = S1_REPL;
          end else begin
            s1_kind_nxt = S1_NONE;
          end
        end
        OP_READ:  s1_kind_nxt = S1_READ;
        OP_CLEAR: s1_kind_nxt = S1_CLEAR;
        default:  s1_kind_nxt = S1_NONE;
      endcase
    end else if (s1_done) begin
      s1_valid_nxt = 1'b0;
    end
  end

  // command toward the back part
  always_comb begin
    q_valid       = s1_valid_r && (s1_kind_r != S1_NONE);
    q_cmd.kind    = CMD_PUSH;
    q_cmd.value   = s1_sample_r;
    case (s1_kind_r)
      S1_MIX:   q_cmd.value = sat_add(pf_old, s1_sample_r);
      S1_REPL:  q_cmd.value = pf_old;
      S1_READ:  q_cmd.kind  = CMD_READ;
      S1_CLEAR: q_cmd.kind  = CMD_CLEAR;
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_valid_r  <= 1'b0;
      pend_stream_r <= '0;
      pos_r         <= '0;
      act_r         <= ACT_STORE;
      s1_valid_r    <= 1'b0;
      s1_kind_r     <= S1_NONE;
    end else begin
      pend_valid_r  <= pend_valid_nxt;
      pend_stream_r <= pend_stream_nxt;
      pos_r         <= pos_nxt;
      act_r         <= act_nxt;
      s1_valid_r    <= s1_valid_nxt;
      s1_kind_r     <= s1_kind_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s1_sample_r <= s1_sample_nxt;
  end
endmodule

/* src/dsam_cmd_q.sv */
// two-entry command queue between front and back
module dsam_cmd_q (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                wr_valid,
  output logic                wr_ready,
  input  dsam_pkg::ring_cmd_t wr_cmd,
  output logic                rd_valid,
  input  logic                rd_ready,
  output dsam_pkg::ring_cmd_t rd_cmd
);
  import dsam_pkg::*;

  localparam int unsigned QDEPTH = 2;
  localparam int unsigned QAW    = 1;
  localparam int unsigned QCW    = 2;

  ring_cmd_t        entries_r [QDEPTH];
  logic [QAW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [QAW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [QCW-1:0]   count_r, count_nxt;
  logic             do_wr;
  logic             do_rd;

  assign wr_ready = (count_r != QCW'(QDEPTH));
  assign rd_valid = (count_r != '0);
  assign rd_cmd   = entries_r[rd_ptr_r];
  assign do_wr    = wr_valid && wr_ready;
  assign do_rd    = rd_valid && rd_ready;

  always_comb begin
    wr_ptr_nxt = do_wr ? wr_ptr_r + QAW'(1) : wr_ptr_r;
    rd_ptr_nxt = do_rd ? rd_ptr_r + QAW'(1) : rd_ptr_r;
    count_nxt  = count_r;
    if (do_wr && !do_rd) begin
      count_nxt = count_r + QCW'(1);
    end else if (do_rd && !do_wr) begin
      count_nxt = count_r - QCW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      entries_r[wr_ptr_r] <= wr_cmd;
    end
  end
endmodule

/* src/dsam_back.sv */
// back part: drop-oldest ring, pointer update and read results
module dsam_back #(
  parameter int unsigned RING_DEPTH = 32768
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cmd_valid,
  output logic                cmd_ready,
  input  dsam_pkg::ring_cmd_t cmd,
  dsam_out_if.source          out_ch
);
  import dsam_pkg::*;

  localparam int unsigned RW  = $clog2(RING_DEPTH);
  localparam int unsigned RW1 = RW + 1;
  localparam logic [RW-1:0]  LAST_IDX  = RW'(RING_DEPTH - 1);
  localparam logic [RW1-1:0] DEPTH_EXT = RW1'(RING_DEPTH);

  function automatic logic [RW-1:0] ptr_inc(input logic [RW-1:0] p);
    return (p == LAST_IDX) ? '0 : p + RW'(1);
  endfunction

  logic [RW-1:0]              rp_r, rp_nxt;
  logic [RW-1:0]              wp_r, wp_nxt;
  logic                       b1_valid_r, b1_valid_nxt;
  logic                       b1_empty_r, b1_empty_nxt;
  logic [FILL_W-1:0]          b1_fill_r, b1_fill_nxt;
  logic                       out_valid_r, out_valid_nxt;
  logic signed [SAMPLE_W-1:0] out_sample_r, out_sample_nxt;
  logic                       out_empty_r, out_empty_nxt;
  logic [FILL_W-1:0]          out_fill_r, out_fill_nxt;

  logic                       out_free;
  logic                       b1_adv;
  logic                       pop;
  logic                       ring_empty;
  logic [RW1-1:0]             fill_ext;
  logic [RW-1:0]              fill;
  logic [RW-1:0]              wp_inc;
  logic                       ram_wr_en;
  logic                       ram_rd_en;
  logic [SAMPLE_W-1:0]        ram_rd_data;

  assign out_free   = !out_valid_r || out_ch.ready;
  assign b1_adv     = b1_valid_r && out_free;
  assign cmd_ready  = !b1_valid_r || out_free;
  assign pop        = cmd_valid && cmd_ready;
  assign ring_empty = (rp_r == wp_r);
  assign wp_inc     = ptr_inc(wp_r);

  // occupancy, wrapping when the write pointer sits below the read pointer
  always_comb begin
    if (wp_r >= rp_r) begin
      fill_ext = {1'b0, wp_r} - {1'b0, rp_r};
    end else begin
      fill_ext = {1'b0, wp_r} + DEPTH_EXT - {1'b0, rp_r};
    end
    fill = fill_ext[RW-1:0];
  end

  assign ram_wr_en = pop && (cmd.kind == CMD_PUSH);
  assign ram_rd_en = pop && (cmd.kind == CMD_READ) && !ring_empty;

  dsam_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (RING_DEPTH)
  ) u_ring_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (wp_r),
    .wr_data (cmd.value),
    .rd_en   (ram_rd_en),
    .rd_addr (rp_r),
    .rd_data (ram_rd_data)
  );

  // pointers
  always_comb begin
    rp_nxt = rp_r;
    wp_nxt = wp_r;
    if (pop) begin
      unique case (cmd.kind)
        CMD_PUSH: begin
          wp_nxt = wp_inc;
          if (wp_inc == rp_r) begin
            rp_nxt = ptr_inc(rp_r);
          end
        end
        CMD_READ: begin
          if (!ring_empty) begin
            rp_nxt = ptr_inc(rp_r);
          end
        end
        CMD_CLEAR: begin
          rp_nxt = '0;
          wp_nxt = '0;
        end
        default: begin
        end
      endcase
    end
  end

  // read stage and output register
  always_comb begin
    b1_valid_nxt   = b1_valid_r;
    b1_empty_nxt   = b1_empty_r;
    b1_fill_nxt    = b1_fill_r;
    out_valid_nxt  = out_valid_r;
    out_sample_nxt = out_sample_r;
    out_empty_nxt  = out_empty_r;
    out_fill_nxt   = out_fill_r;
    if (pop && (cmd.kind == CMD_READ)) begin
      b1_valid_nxt = 1'b1;
      b1_empty_nxt = ring_empty;
      b1_fill_nxt  = ring_empty ? '0 : FILL_W'(fill);
    end else if (b1_adv) begin
      b1_valid_nxt = 1'b0;
    end
    if (b1_adv) begin
      out_valid_nxt  = 1'b1;
      out_sample_nxt = b1_empty_r ? '0 : ram_rd_data;
      out_empty_nxt  = b1_empty_r;
      out_fill_nxt   = b1_fill_r;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rp_r        <= '0;
      wp_r        <= '0;
      b1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      rp_r        <= rp_nxt;
      wp_r        <= wp_nxt;
      b1_valid_r  <= b1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    b1_empty_r   <= b1_empty_nxt;
    b1_fill_r    <= b1_fill_nxt;
    out_sample_r <= out_sample_nxt;
    out_empty_r  <= out_empty_nxt;
    out_fill_r   <= out_fill_nxt;
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.sample_out = out_sample_r;
  assign out_ch.was_empty  = out_empty_r;
  assign out_ch.fill_level = out_fill_r;
endmodule

/* src/dual_stream_audio_mixer_ring_core.sv */
// throughput: one item per cycle, any op, one command per stage per cycle, unless out_ch stalls
// read path: a read item passes through the front stage (with pending-frame ram read),
//   the command queue, the ring ram read and the output register before its result is valid
// reset: synchronous active-low rst_n empties the ring and the queue and drops the pending frame
//   at once; both rams are left uninitialized, no clearing pass is needed
module dual_stream_audio_mixer_ring_core #(
  parameter int unsigned RING_DEPTH = 32768,
  parameter int unsigned FRAME_LEN  = 80
) (
  input  logic        clk,
  input  logic        rst_n,
  dsam_in_if.sink     in_ch,
  dsam_out_if.source  out_ch
);
  import dsam_pkg::*;

  // front to queue
  logic      fq_valid;
  logic      fq_ready;
  ring_cmd_t fq_cmd;

  // queue to back
  logic      qb_valid;
  logic      qb_ready;
  ring_cmd_t qb_cmd;

  // front decides store, mix or replace at a frame's first sample and keeps
  // the pending frame in its own ram, so the back only sees plain ring commands
  dsam_front #(
    .FRAME_LEN (FRAME_LEN)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .q_valid (fq_valid),
    .q_ready (fq_ready),
    .q_cmd   (fq_cmd)
  );

  // short queue lets the front keep taking items while the result side stalls, until it fills
  dsam_cmd_q u_cmd_q (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (fq_valid),
    .wr_ready (fq_ready),
    .wr_cmd   (fq_cmd),
    .rd_valid (qb_valid),
    .rd_ready (qb_ready),
    .rd_cmd   (qb_cmd)
  );

  // back owns the ring: a push into a full ring drops the oldest sample
  dsam_back #(
    .RING_DEPTH (RING_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (qb_valid),
    .cmd_ready (qb_ready),
    .cmd       (qb_cmd),
    .out_ch    (out_ch)
  );
endmodule
